/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on i_clk and are switched off while i_rst_n is low.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int SPQ_DEPTH_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 7;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_LIST   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP,
        OP_ROTATE,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    load;
        t_status status;
        logic    last;
        logic    idx_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/spq_dp.sv */
`default_nettype none

module spq_dp #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  spq_pkg::t_dp_cmd             i_cmd,
    input  wire signed [31:0]            i_value,
    output spq_pkg::t_dp_stat            o_stat,
    output logic signed [31:0]           o_data,
    output spq_pkg::t_status             o_status,
    output logic                         o_last,
    output logic [6:0]                   o_occ
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [DATA_W-1:0] r_entries [DEPTH];
    logic signed [DATA_W-1:0] n_entries [DEPTH];
    logic [DEPTH-1:0]         w_smaller;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            w_count_m1;
    logic [IW-1:0]            r_idx;
    logic signed [DATA_W-1:0] r_data;
    t_status                  r_status;
    logic                     r_last;
    logic [OCC_W-1:0]         r_occ;

    assign w_count_m1 = r_count - CW'(1);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign w_smaller[i] = (CW'(i) < r_count) && (r_entries[i] < i_value);

        always_comb begin
            n_entries[i] = r_entries[i];
            case (i_cmd.op)
                OP_INSERT: begin
                    if (!w_smaller[i]) begin
                        if (i == 0) begin
                            n_entries[i] = i_value;
                        end else if (w_smaller[(i > 0) ? i - 1 : 0]) begin
                            n_entries[i] = i_value;
                        end else begin
                            n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
                OP_POP: begin
                    if (i < DEPTH - 1) begin
                        n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                OP_ROTATE: begin
                    if (CW'(i) == w_count_m1) begin
                        n_entries[i] = r_entries[0];
                    end else if (i < DEPTH - 1) begin
                        n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
                default: begin
                    n_entries[i] = r_entries[i];
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            OP_INSERT: n_count = r_count + CW'(1);
            OP_POP:    n_count = w_count_m1;
            OP_CLEAR:  n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.op == OP_ROTATE) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.load) begin
            if (i_cmd.op == OP_POP || i_cmd.op == OP_ROTATE) begin
                r_data <= r_entries[0];
            end else begin
                r_data <= '0;
            end
            r_status <= i_cmd.status;
            r_last   <= i_cmd.last;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.list_last = (CW'(r_idx) == w_count_m1);

    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;
    assign o_occ    = r_occ;

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  spq_pkg::t_action    i_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  spq_pkg::t_dp_stat   i_stat,
    output spq_pkg::t_dp_cmd    o_cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_out_free;
    logic    w_accept;
    t_dp_cmd w_cmd;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        w_cmd.op       = OP_NONE;
        w_cmd.load     = 1'b0;
        w_cmd.status   = ST_OK;
        w_cmd.last     = 1'b1;
        w_cmd.idx_clr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_INSERT: begin
                            w_cmd.load = 1'b1;
                            if (i_stat.full) begin
                                w_cmd.status = ST_FULL;
                            end else begin
                                w_cmd.op = OP_INSERT;
                            end
                        end
                        ACT_POP: begin
                            w_cmd.load = 1'b1;
                            if (i_stat.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.op = OP_POP;
                            end
                        end
                        ACT_LIST: begin
                            if (i_stat.empty) begin
                                w_cmd.load   = 1'b1;
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.idx_clr = 1'b1;
                                n_state       = S_LIST;
                            end
                        end
                        ACT_CLEAR: begin
                            w_cmd.load = 1'b1;
                            if (i_stat.empty) begin
                                w_cmd.status = ST_EMPTY;
                            end else begin
                                w_cmd.op = OP_CLEAR;
                            end
                        end
                        default: begin
                            w_cmd.load = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    w_cmd.load = 1'b1;
                    w_cmd.op   = OP_ROTATE;
                    w_cmd.last = i_stat.list_last;
                    if (i_stat.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Insert, pop and clear: the result appears in the cycle after the item is accepted.
// Those actions sustain one item per cycle while results are taken at once.
// A list of N stored entries gives N results from the rotating entry row, one per cycle
// while results are taken at once; the first passes the state register, then the data
// register. The next item can be taken at the edge that takes the last result.
// Synchronous active-low reset empties the queue; the entry storage itself is not cleared.
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // value[31:0]
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data[31:0], occupancy[38:32], zero fill[39]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import spq_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic signed [31:0] w_data;
    t_status            w_status;
    logic               w_last;
    logic [OCC_W-1:0]   w_occ;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_action    (t_action'(s_axis_tuser)),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (s_axis_tdata),
        .o_stat   (w_stat),
        .o_data   (w_data),
        .o_status (w_status),
        .o_last   (w_last),
        .o_occ    (w_occ)
    );

    assign m_axis_tdata = {1'b0, w_occ, w_data};
    assign m_axis_tuser = w_status;
    assign m_axis_tlast = w_last;

    `SPQ_ASSERT_SAME(a_full_at_depth, m_axis_tvalid && m_axis_tuser == ST_FULL,
        m_axis_tdata[38:32] == OCC_W'(DEPTH), "full status without a full queue")
    `SPQ_ASSERT_SAME(a_empty_zero, m_axis_tvalid && m_axis_tuser == ST_EMPTY,
        m_axis_tdata == '0 && m_axis_tlast, "empty status with data or occupancy")
    `SPQ_ASSERT_SAME(a_notlast_ok, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser == ST_OK, "listed item that is not last has a bad status")
    `SPQ_ASSERT_NEXT(a_single_result,
        s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_LIST,
        m_axis_tvalid && m_axis_tlast, "single-result action gave no result")

endmodule

`default_nettype wire

/* verif/tb_sorted_priority_queue.sv */
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int QDEPTH         = SPQ_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 272;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 120;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        t_status           status;
        logic              last;
        logic [OCC_W-1:0]  occ;
    } t_qresult;

    typedef struct {
        t_action     act;
        logic [31:0] value;
        int          reps;
        bit          typed;
        t_qresult    exp;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // value[31:0]
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // data[31:0], occupancy[38:32], zero fill[39]
    logic [1:0]  m_axis_tuser;   // status[1:0]
    logic        m_axis_tlast;

    logic signed [31:0] shadow_entries[$];
    t_qresult           pending_results[$];
    t_stim_row          stim_table[$];
    int                 fail_count;
    int                 results_seen;
    bit                 long_hold_done;

    sorted_priority_queue #(.DEPTH(QDEPTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_queue_action(t_action act, logic signed [31:0] val);
        t_qresult r;
        int       pos;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (act)
            ACT_INSERT: begin
                if (shadow_entries.size() >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < shadow_entries.size() && shadow_entries[pos] < val)
                        pos++;
                    shadow_entries.insert(pos, val);
                end
                r.occ = OCC_W'(shadow_entries.size());
                pending_results.push_back(r);
            end
            ACT_POP: begin
                if (shadow_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data = shadow_entries.pop_front();
                end
                r.occ = OCC_W'(shadow_entries.size());
                pending_results.push_back(r);
            end
            ACT_LIST: begin
                if (shadow_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    for (int i = 0; i < shadow_entries.size(); i++) begin
                        r.data = shadow_entries[i];
                        r.last = (i == shadow_entries.size() - 1);
                        r.occ = OCC_W'(shadow_entries.size());
                        pending_results.push_back(r);
                    end
                end
            end
            default: begin
                if (shadow_entries.size() == 0)
                    r.status = ST_EMPTY;
                shadow_entries.delete();
                pending_results.push_back(r);
            end
        endcase
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic void check_result();
        t_qresult e;
        string    exp_s;
        string    got_s;
        if (pending_results.size() == 0) begin
            report_failure($sformatf("unexpected result tdata=%h tuser=%h tlast=%b",
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast));
            return;
        end
        e = pending_results.pop_front();
        if (m_axis_tdata !== {1'b0, e.occ, e.data} || m_axis_tuser !== e.status ||
            m_axis_tlast !== e.last) begin
            exp_s = $sformatf("exp data=%h status=%0d last=%b occ=%0d",
                              e.data, e.status, e.last, e.occ);
            got_s = $sformatf("got data=%h status=%0d last=%b occ=%0d fill=%b",
                              m_axis_tdata[31:0], m_axis_tuser, m_axis_tlast,
                              m_axis_tdata[38:32], m_axis_tdata[39]);
            report_failure($sformatf("result %0d: %s, %s", results_seen, exp_s, got_s));
        end
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_action random_action(int bias);
        int r;
        int ins_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (bias)
            0: begin
                ins_lim = 70;
                pop_lim = 85;
            end
            1: begin
                ins_lim = 20;
                pop_lim = 75;
            end
            default: begin
                ins_lim = 42;
                pop_lim = 77;
            end
        endcase
        if (r < ins_lim)
            return ACT_INSERT;
        if (r < pop_lim)
            return ACT_POP;
        if (r < 96)
            return ACT_LIST;
        return ACT_CLEAR;
    endfunction

    function automatic logic [31:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 8)
            return 32'($urandom_range(0, 15)) - 32'd8;
        if (r == 8) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return '0;
                default: return '1;
            endcase
        end
        if (shadow_entries.size() > 0)
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
        return $urandom;
    endfunction

    function automatic void add_row(t_action act, logic [31:0] val, int reps, bit typed,
                                    logic [31:0] exp_data, t_status exp_status, int exp_occ);
        t_stim_row row;
        row.act = act;
        row.value = val;
        row.reps = reps;
        row.typed = typed;
        row.exp.data = exp_data;
        row.exp.status = exp_status;
        row.exp.last = 1'b1;
        row.exp.occ = OCC_W'(exp_occ);
        stim_table.push_back(row);
    endfunction

    task automatic send_item(t_action act, logic [31:0] val, int gap, bit typed,
                             t_qresult exp);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= val;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_queue_action(act, val);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(exp);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_stim_row row;
        fail_count = 0;
        results_seen = 0;
        long_hold_done = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_INSERT;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(ACT_POP,    32'h1234_5678, 1,  1, '0,            ST_EMPTY, 0);
        add_row(ACT_LIST,   32'hFFFF_FFFF, 1,  1, '0,            ST_EMPTY, 0);
        add_row(ACT_CLEAR,  32'h0000_0000, 1,  1, '0,            ST_EMPTY, 0);
        add_row(ACT_INSERT, 32'h7FFF_FFFF, 1,  1, '0,            ST_OK,    1);
        add_row(ACT_INSERT, 32'h8000_0000, 1,  1, '0,            ST_OK,    2);
        add_row(ACT_INSERT, 32'h0000_0000, 1,  1, '0,            ST_OK,    3);
        add_row(ACT_INSERT, 32'hFFFF_FFFF, 1,  1, '0,            ST_OK,    4);
        add_row(ACT_INSERT, 32'h0000_0000, 1,  1, '0,            ST_OK,    5);
        add_row(ACT_LIST,   32'h5A5A_5A5A, 1,  0, '0,            ST_OK,    0);
        add_row(ACT_POP,    32'hA5A5_A5A5, 1,  1, 32'h8000_0000, ST_OK,    4);
        add_row(ACT_POP,    32'h0000_0000, 1,  1, 32'hFFFF_FFFF, ST_OK,    3);
        add_row(ACT_INSERT, 32'h7FFF_FFFF, 1,  1, '0,            ST_OK,    4);
        add_row(ACT_LIST,   32'h0000_0000, 1,  0, '0,            ST_OK,    0);
        add_row(ACT_CLEAR,  32'hFFFF_FFFF, 1,  1, '0,            ST_OK,    0);
        add_row(ACT_INSERT, 32'd100,       16, 0, '0,            ST_OK,    0);
        add_row(ACT_INSERT, 32'h5555_5555, 1,  1, '0,            ST_FULL,  16);
        add_row(ACT_LIST,   32'h0000_0000, 1,  0, '0,            ST_OK,    0);
        add_row(ACT_POP,    32'h0000_0000, 1,  0, '0,            ST_OK,    0);
        add_row(ACT_INSERT, 32'hAAAA_AAAA, 1,  1, '0,            ST_OK,    16);
        add_row(ACT_INSERT, 32'h0000_0000, 1,  1, '0,            ST_FULL,  16);
        add_row(ACT_CLEAR,  32'h0000_0000, 1,  1, '0,            ST_OK,    0);
        add_row(ACT_POP,    32'h0000_0000, 1,  1, '0,            ST_EMPTY, 0);
        add_row(ACT_LIST,   32'h0000_0000, 1,  1, '0,            ST_EMPTY, 0);

        foreach (stim_table[n]) begin
            row = stim_table[n];
            for (int k = 0; k < row.reps; k++)
                send_item(row.act, row.value - 32'(3 * k), pick_gap(1'b0), row.typed, row.exp);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_action((n / 50) % 3), random_value(),
                      pick_gap(((n / 40) % 3) == 1), 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        int rx_hold;
        bit took;
        rx_hold = 0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            took = m_axis_tvalid && m_axis_tready;
            if (took) begin
                check_result();
                results_seen++;
                // One long stall lets the queue back up until the input side stops.
                if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                    long_hold_done = 1'b1;
                    rx_hold = LONG_HOLD;
                end else begin
                    rx_hold = pick_gap(((results_seen / 50) % 3) == 2);
                end
            end else if (rx_hold == 0 && $urandom_range(0, 15) == 0) begin
                rx_hold = $urandom_range(1, 4);
            end
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
